/* hw/rtl/sal_pkg.sv */
// Package for the stack allocator with marks: widths, codes and shared types.
// Used by the top level, the engine and the checker through scoped names; no dependencies.
`timescale 1ns / 1ps

package sal_pkg;

    // Field and state widths
    localparam int ADDR_W      = 32;
    localparam int SPACE_W     = 22;
    localparam int SIZE_W      = 24;
    localparam int ASIZE_W     = SIZE_W + 1;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int MARK_W      = 2;

    // Sizes of the stores
    localparam int MAX_BLOCKS  = 256;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int MARK_SLOTS  = 4;
    localparam int ALIGN_BYTES = 8;

    // Register defaults
    localparam logic [ADDR_W-1:0]  POOL_BASE_RST = '0;
    localparam logic [SPACE_W-1:0] POOL_SIZE_RST = SPACE_W'(2097152);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
    localparam logic [OP_W-1:0] OP_RESIZE    = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_MARK  = 3'd3;
    localparam logic [OP_W-1:0] OP_FREE_MARK = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_TOP   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd5;

    // One request item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              is_null;
        logic [MARK_W-1:0] mark;
    } t_req;

    // One result item
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] status;
        logic [SPACE_W-1:0]  free;
    } t_res;

    // Write port of the size stack
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [SPACE_W-1:0] data;
    } t_wr;

    // Read addresses of the size stack (top entry and the one below it)
    typedef struct packed {
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] below;
    } t_rd;

endpackage

/* hw/rtl/stack_allocator_with_marks_top.sv */
// A request item is captured when accepted; its result is computed in the execute state
// and registered at the output once the output slot is free. Only one item is in work at a time.
// The block takes the next item while the previous result still waits at the output.
// Reset: synchronous, active low; loads pool base and size defaults and clears the
// stack and all marks. The size stack RAM is not cleared and needs no clearing pass.
// Depends on sal_pkg, sal_ram and sal_engine.
`timescale 1ns / 1ps

module stack_allocator_with_marks_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_wen,
    input  logic [sal_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [sal_pkg::ADDR_W-1:0]     i_cfg_wdata,
    // Request items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [63:0]                    s_axis_tdata,  // request_size, block_address, mark_index
    input  logic [3:0]                     s_axis_tuser,  // operation, address_is_null
    // Result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [55:0]                    m_axis_tdata,  // result_address, free_space
    output logic [2:0]                     m_axis_tuser   // status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state          r_state, n_state;
    sal_pkg::t_req   r_req;
    sal_pkg::t_res   r_out;
    logic            r_out_valid;
    sal_pkg::t_res   w_res;
    sal_pkg::t_rd    w_rd;
    sal_pkg::t_wr    w_wr;
    logic [sal_pkg::SPACE_W-1:0] w_rd_top;
    logic [sal_pkg::SPACE_W-1:0] w_rd_below;
    logic            w_accept;
    logic            w_load;

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.size    <= s_axis_tdata[23:0];
            r_req.addr    <= s_axis_tdata[55:24];
            r_req.mark    <= s_axis_tdata[57:56];
            r_req.op      <= s_axis_tuser[2:0];
            r_req.is_null <= s_axis_tuser[3];
        end
    end

    // Sequencer: accept, then execute once the output slot is free
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.free, r_out.addr};
    assign m_axis_tuser  = r_out.status;

    // Allocator state and update logic
    sal_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_exec      (w_load),
        .i_req       (r_req),
        .i_rd_top    (w_rd_top),
        .i_rd_below  (w_rd_below),
        .o_rd        (w_rd),
        .o_wr        (w_wr),
        .o_res       (w_res)
    );

    // Size stack, mirrored so the top entry and the one below read together
    sal_ram #(
        .WIDTH (sal_pkg::SPACE_W),
        .DEPTH (sal_pkg::MAX_BLOCKS)
    ) u_size_top (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_rd.top),
        .o_rdata (w_rd_top)
    );

    sal_ram #(
        .WIDTH (sal_pkg::SPACE_W),
        .DEPTH (sal_pkg::MAX_BLOCKS)
    ) u_size_below (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_rd.below),
        .o_rdata (w_rd_below)
    );

endmodule

/* hw/rtl/sal_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module sal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sal_engine.sv */
// Allocator state registers, mark slots and the per-request update logic.
// Depends on sal_pkg; the size stack itself lives in RAMs outside this module.
`timescale 1ns / 1ps

module sal_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [sal_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [sal_pkg::ADDR_W-1:0]        i_cfg_wdata,
    input  logic                              i_exec,
    input  sal_pkg::t_req                     i_req,
    input  logic [sal_pkg::SPACE_W-1:0]       i_rd_top,
    input  logic [sal_pkg::SPACE_W-1:0]       i_rd_below,
    output sal_pkg::t_rd                      o_rd,
    output sal_pkg::t_wr                      o_wr,
    output sal_pkg::t_res                     o_res
);

    localparam logic [sal_pkg::ASIZE_W-1:0] ALIGN_MASK =
        sal_pkg::ASIZE_W'(sal_pkg::ALIGN_BYTES - 1);
    localparam int PAD_W = sal_pkg::ASIZE_W - sal_pkg::SPACE_W;

    // Configuration registers
    logic [sal_pkg::ADDR_W-1:0]  r_pool_base, n_pool_base;
    logic [sal_pkg::SPACE_W-1:0] r_pool_size, n_pool_size;

    // Live allocator state
    logic [sal_pkg::ADDR_W-1:0]  r_next_free, n_next_free;
    logic [sal_pkg::ADDR_W-1:0]  r_top_block, n_top_block;
    logic [sal_pkg::SPACE_W-1:0] r_free_bytes, n_free_bytes;
    logic [sal_pkg::CNT_W-1:0]   r_block_count, n_block_count;

    // Saved states
    logic [sal_pkg::ADDR_W-1:0]  r_mark_next [sal_pkg::MARK_SLOTS];
    logic [sal_pkg::ADDR_W-1:0]  r_mark_top [sal_pkg::MARK_SLOTS];
    logic [sal_pkg::SPACE_W-1:0] r_mark_free [sal_pkg::MARK_SLOTS];
    logic [sal_pkg::CNT_W-1:0]   r_mark_count [sal_pkg::MARK_SLOTS];

    logic [sal_pkg::ASIZE_W-1:0] w_asize;
    logic [sal_pkg::ASIZE_W-1:0] w_free_ext;
    logic [sal_pkg::ASIZE_W-1:0] w_old_ext;
    logic [sal_pkg::CNT_W-1:0]   w_cnt_m1;
    logic [sal_pkg::CNT_W-1:0]   w_cnt_m2;
    logic                        w_set_mark;

    // Aligned request size and widened operands
    assign w_asize    = ({1'b0, i_req.size} + ALIGN_MASK) & ~ALIGN_MASK;
    assign w_free_ext = {{PAD_W{1'b0}}, r_free_bytes};
    assign w_old_ext  = {{PAD_W{1'b0}}, i_rd_top};
    assign w_cnt_m1   = r_block_count - sal_pkg::CNT_W'(1);
    assign w_cnt_m2   = r_block_count - sal_pkg::CNT_W'(2);

    // The size stack is read continuously at the top entry and the one below
    assign o_rd.top   = w_cnt_m1[sal_pkg::IDX_W-1:0];
    assign o_rd.below = w_cnt_m2[sal_pkg::IDX_W-1:0];

    // Request evaluation
    always_comb begin
        logic do_alloc;
        do_alloc      = 1'b0;
        n_next_free   = r_next_free;
        n_top_block   = r_top_block;
        n_free_bytes  = r_free_bytes;
        n_block_count = r_block_count;
        w_set_mark    = 1'b0;
        o_wr          = '0;
        o_res.addr    = '0;
        o_res.status  = sal_pkg::ST_OK;

        unique case (i_req.op)
            sal_pkg::OP_ALLOC: begin
                do_alloc = 1'b1;
            end
            sal_pkg::OP_RESIZE: begin
                if (i_req.is_null) begin
                    do_alloc = 1'b1;
                end else if (i_req.addr != r_top_block || r_block_count == '0) begin
                    o_res.status = sal_pkg::ST_NOT_TOP;
                end else if (w_asize > w_old_ext && (w_asize - w_old_ext) > w_free_ext) begin
                    o_res.status = sal_pkg::ST_NO_SPACE;
                end else begin
                    n_free_bytes = sal_pkg::SPACE_W'(w_free_ext + w_old_ext - w_asize);
                    n_next_free  = r_top_block + sal_pkg::ADDR_W'(w_asize);
                    o_wr.en      = 1'b1;
                    o_wr.addr    = w_cnt_m1[sal_pkg::IDX_W-1:0];
                    o_wr.data    = w_asize[sal_pkg::SPACE_W-1:0];
                    o_res.addr   = r_top_block;
                end
            end
            sal_pkg::OP_FREE: begin
                if (!i_req.is_null) begin
                    if (i_req.addr != r_top_block) begin
                        o_res.status = sal_pkg::ST_NOT_TOP;
                    end else if (r_block_count == '0) begin
                        o_res.status = sal_pkg::ST_NOTHING;
                    end else begin
                        n_block_count = w_cnt_m1;
                        n_free_bytes  = r_free_bytes + i_rd_top;
                        n_next_free   = r_top_block;
                        if (w_cnt_m1 != '0) begin
                            n_top_block = r_top_block - sal_pkg::ADDR_W'(i_rd_below);
                        end
                    end
                end
            end
            sal_pkg::OP_SET_MARK: begin
                w_set_mark = 1'b1;
            end
            sal_pkg::OP_FREE_MARK: begin
                n_next_free   = r_mark_next[i_req.mark];
                n_top_block   = r_mark_top[i_req.mark];
                n_free_bytes  = r_mark_free[i_req.mark];
                n_block_count = r_mark_count[i_req.mark];
            end
            default: begin
                // Unused codes leave the state alone.
            end
        endcase

        // Shared push path for allocate and null resize
        if (do_alloc) begin
            if (i_req.size == '0) begin
                o_res.status = sal_pkg::ST_ZERO_SIZE;
            end else if (w_asize > w_free_ext) begin
                o_res.status = sal_pkg::ST_NO_SPACE;
            end else if (r_block_count >= sal_pkg::CNT_W'(sal_pkg::MAX_BLOCKS)) begin
                o_res.status = sal_pkg::ST_TOO_MANY;
            end else begin
                n_top_block   = r_next_free;
                n_next_free   = r_next_free + sal_pkg::ADDR_W'(w_asize);
                n_free_bytes  = r_free_bytes - w_asize[sal_pkg::SPACE_W-1:0];
                n_block_count = r_block_count + sal_pkg::CNT_W'(1);
                o_wr.en       = 1'b1;
                o_wr.addr     = r_block_count[sal_pkg::IDX_W-1:0];
                o_wr.data     = w_asize[sal_pkg::SPACE_W-1:0];
                o_res.addr    = r_next_free;
            end
        end

        o_res.free = n_free_bytes;
        o_wr.en    = o_wr.en & i_exec;
    end

    // Register values after a configuration write
    always_comb begin
        n_pool_base = r_pool_base;
        n_pool_size = r_pool_size;
        if (i_cfg_wen) begin
            if (i_cfg_addr == sal_pkg::REG_POOL_BASE) begin
                n_pool_base = i_cfg_wdata;
            end else begin
                n_pool_size = i_cfg_wdata[sal_pkg::SPACE_W-1:0];
            end
        end
    end

    // State update: reset loads the defaults; reset and configuration writes reinitialize the live state and all marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wen) begin
            r_pool_base   <= i_rst_n ? n_pool_base : sal_pkg::POOL_BASE_RST;
            r_pool_size   <= i_rst_n ? n_pool_size : sal_pkg::POOL_SIZE_RST;
            r_next_free   <= i_rst_n ? n_pool_base : sal_pkg::POOL_BASE_RST;
            r_top_block   <= i_rst_n ? n_pool_base : sal_pkg::POOL_BASE_RST;
            r_free_bytes  <= i_rst_n ? n_pool_size : sal_pkg::POOL_SIZE_RST;
            r_block_count <= '0;
            for (int i = 0; i < sal_pkg::MARK_SLOTS; i++) begin
                r_mark_next[i]  <= i_rst_n ? n_pool_base : sal_pkg::POOL_BASE_RST;
                r_mark_top[i]   <= i_rst_n ? n_pool_base : sal_pkg::POOL_BASE_RST;
                r_mark_free[i]  <= i_rst_n ? n_pool_size : sal_pkg::POOL_SIZE_RST;
                r_mark_count[i] <= '0;
            end
        end else if (i_exec) begin
            r_next_free   <= n_next_free;
            r_top_block   <= n_top_block;
            r_free_bytes  <= n_free_bytes;
            r_block_count <= n_block_count;
            if (w_set_mark) begin
                r_mark_next[i_req.mark]  <= r_next_free;
                r_mark_top[i_req.mark]   <= r_top_block;
                r_mark_free[i_req.mark]  <= r_free_bytes;
                r_mark_count[i_req.mark] <= r_block_count;
            end
        end
    end

endmodule

/* hw/rtl/sal_checker.sv */
// Port-level checks for the stack allocator, bound to the top level.
// Depends on sal_pkg for the status codes.
`timescale 1ns / 1ps

module sal_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [55:0]                    m_axis_tdata,
    input  logic [2:0]                     m_axis_tuser
);

    // A held result item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // One request item is worked on at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request item accepted while busy");

    // Only defined status codes appear
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= sal_pkg::ST_NOTHING)
        else $error("undefined status code");

    // A failed request returns a zero address
    a_err_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != sal_pkg::ST_OK |-> m_axis_tdata[31:0] == '0)
        else $error("failed request returned an address");

endmodule

bind stack_allocator_with_marks_top sal_checker u_sal_checker (.*);
